### sv/rgbay_pkg.sv
`default_nettype none

package rgbay_pkg;

    // channel and arithmetic widths
    localparam int ChanW    = 8;
    localparam int MixW     = 16;
    localparam int CoefW    = 16;
    localparam int ProdW    = ChanW + CoefW;
    localparam int SumW     = ProdW + 2;
    localparam int FracBits = 16;

    typedef logic [ChanW-1:0] chan_t;
    typedef logic [MixW-1:0]  mix_t;
    typedef logic [CoefW-1:0] coef_t;
    typedef logic [ProdW-1:0] prod_t;
    typedef logic signed [SumW-1:0] sum_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } rgba_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    typedef struct packed {
        sum_t luma;
        sum_t chroma_blue;
        sum_t chroma_red;
    } ycc_sum_t;

    // bt.601 full range, 16 fraction bits
    localparam coef_t CoefYR  = 16'd19595;
    localparam coef_t CoefYG  = 16'd38470;
    localparam coef_t CoefYB  = 16'd7471;
    localparam coef_t CoefCbR = 16'd11056;
    localparam coef_t CoefCbG = 16'd21712;
    localparam coef_t CoefCbB = 16'd32768;
    localparam coef_t CoefCrR = 16'd32768;
    localparam coef_t CoefCrG = 16'd27440;
    localparam coef_t CoefCrB = 16'd5328;

    localparam sum_t ChromaOffset = sum_t'(128 * 65536);

    // configuration register indexes
    localparam int CfgIndexW = 2;
    typedef logic [CfgIndexW-1:0] cfg_index_t;
    localparam cfg_index_t RegBackRed   = 2'd0;
    localparam cfg_index_t RegBackGreen = 2'd1;
    localparam cfg_index_t RegBackBlue  = 2'd2;

endpackage

`default_nettype wire

### sv/rgbay_blend.sv
`default_nettype none

// alpha blend over the background: products and sum, then divide by 255
module rgbay_blend (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rgbay_pkg::rgba_t in_pix,
    input  wire rgbay_pkg::rgb_t  back,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rgbay_pkg::rgb_t     out_rgb
);
    import rgbay_pkg::*;

    function automatic mix_t mix_chan(input chan_t fg, input chan_t bg, input chan_t a);
        logic [MixW:0] acc;
        acc = {1'b0, mix_t'(fg) * mix_t'(a)}
            + {1'b0, mix_t'(bg) * mix_t'(chan_t'(8'd255) - a)};
        return acc[MixW-1:0];
    endfunction

    // floor(x / 255) for x below 65280
    function automatic chan_t div255(input mix_t x);
        logic [MixW:0] t;
        t = (MixW+1)'(x) + (MixW+1)'(x >> ChanW) + (MixW+1)'(1);
        return t[MixW-1:ChanW];
    endfunction

    mix_t  mix_r_reg, mix_g_reg, mix_b_reg;
    logic  mix_valid_reg;
    rgb_t  rgb_reg;
    logic  rgb_valid_reg;
    logic  mix_ready, rgb_ready;

    assign rgb_ready = !rgb_valid_reg || out_ready;
    assign mix_ready = !mix_valid_reg || rgb_ready;
    assign in_ready  = mix_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_valid_reg <= 1'b0;
        end else if (mix_ready) begin
            mix_valid_reg <= in_valid;
        end
        if (mix_ready) begin
            mix_r_reg <= mix_chan(in_pix.red,   back.red,   in_pix.alpha);
            mix_g_reg <= mix_chan(in_pix.green, back.green, in_pix.alpha);
            mix_b_reg <= mix_chan(in_pix.blue,  back.blue,  in_pix.alpha);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rgb_valid_reg <= 1'b0;
        end else if (rgb_ready) begin
            rgb_valid_reg <= mix_valid_reg;
        end
        if (rgb_ready) begin
            rgb_reg.red   <= div255(mix_r_reg);
            rgb_reg.green <= div255(mix_g_reg);
            rgb_reg.blue  <= div255(mix_b_reg);
        end
    end

    assign out_valid = rgb_valid_reg;
    assign out_rgb   = rgb_reg;

endmodule

`default_nettype wire

### sv/rgbay_matrix.sv
`default_nettype none

// colour matrix: nine products, then three signed sums
module rgbay_matrix (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rgbay_pkg::rgb_t in_rgb,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rgbay_pkg::ycc_sum_t out_sum
);
    import rgbay_pkg::*;

    prod_t yr_reg, yg_reg, yb_reg;
    prod_t cbr_reg, cbg_reg, cbb_reg;
    prod_t crr_reg, crg_reg, crb_reg;
    logic  prod_valid_reg;
    ycc_sum_t sum_reg;
    logic  sum_valid_reg;
    logic  prod_ready, sum_ready;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= in_valid;
        end
        if (prod_ready) begin
            yr_reg  <= prod_t'(in_rgb.red)   * prod_t'(CoefYR);
            yg_reg  <= prod_t'(in_rgb.green) * prod_t'(CoefYG);
            yb_reg  <= prod_t'(in_rgb.blue)  * prod_t'(CoefYB);
            cbr_reg <= prod_t'(in_rgb.red)   * prod_t'(CoefCbR);
            cbg_reg <= prod_t'(in_rgb.green) * prod_t'(CoefCbG);
            cbb_reg <= prod_t'(in_rgb.blue)  * prod_t'(CoefCbB);
            crr_reg <= prod_t'(in_rgb.red)   * prod_t'(CoefCrR);
            crg_reg <= prod_t'(in_rgb.green) * prod_t'(CoefCrG);
            crb_reg <= prod_t'(in_rgb.blue)  * prod_t'(CoefCrB);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            sum_valid_reg <= prod_valid_reg;
        end
        if (sum_ready) begin
            sum_reg.luma <= sum_t'({2'b00, yr_reg}) + sum_t'({2'b00, yg_reg})
                          + sum_t'({2'b00, yb_reg});
            sum_reg.chroma_blue <= ChromaOffset - sum_t'({2'b00, cbr_reg})
                                 - sum_t'({2'b00, cbg_reg}) + sum_t'({2'b00, cbb_reg});
            sum_reg.chroma_red  <= ChromaOffset + sum_t'({2'b00, crr_reg})
                                 - sum_t'({2'b00, crg_reg}) - sum_t'({2'b00, crb_reg});
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_sum   = sum_reg;

endmodule

`default_nettype wire

### sv/rgba_blend_to_ycbcr444.sv
`default_nettype none

// rgba to full-range bt.601 ycbcr 4:4:4, one pixel per item. each pixel is
// first blended over an opaque background colour held in three registers,
// c = floor((fg*alpha + bg*(255-alpha)) / 255), then converted with 16-bit
// fraction coefficients, the fraction dropped and each result clamped to a
// byte. the datapath is a five-stage pipeline (blend products, divide by 255,
// matrix products, matrix sums, clamp and output register): one item enters
// per clock while s_tready is high, and each item passes through the stages
// in that order. each stage holds its item while the stage after it is full
// and cannot pass its own item on, so s_tready falls only when every stage is
// occupied and m_tready is low. the background registers are written through
// the cfg channel, which is always ready; write them only while the pipeline
// is empty.
module rgba_blend_to_ycbcr444 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // red, green, blue, alpha
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // luma, chroma_blue, chroma_red
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire rgbay_pkg::cfg_index_t cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import rgbay_pkg::*;

    // drop fraction, clamp to 0..255
    function automatic chan_t clamp_byte(input sum_t s);
        sum_t v;
        chan_t res;
        v = s >>> FracBits;
        if (s < 0) begin
            res = '0;
        end else if (v > sum_t'(255)) begin
            res = 8'd255;
        end else begin
            res = v[ChanW-1:0];
        end
        return res;
    endfunction

    // background colour registers
    rgb_t back_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            back_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                RegBackRed:   back_reg.red   <= cfg_data;
                RegBackGreen: back_reg.green <= cfg_data;
                RegBackBlue:  back_reg.blue  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack input item
    rgba_t in_pix;
    assign in_pix.red   = s_tdata[7:0];
    assign in_pix.green = s_tdata[15:8];
    assign in_pix.blue  = s_tdata[23:16];
    assign in_pix.alpha = s_tdata[31:24];

    // blend stages
    logic     blend_valid, blend_ready;
    rgb_t     blend_rgb;

    rgbay_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .back      (back_reg),
        .out_valid (blend_valid),
        .out_ready (blend_ready),
        .out_rgb   (blend_rgb)
    );

    // matrix stages
    logic     mat_valid, mat_ready;
    ycc_sum_t mat_sum;

    rgbay_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (blend_valid),
        .in_ready  (blend_ready),
        .in_rgb    (blend_rgb),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_sum   (mat_sum)
    );

    // clamp and output register
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    assign mat_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mat_ready) begin
            out_valid_reg <= mat_valid;
        end
        if (mat_ready) begin
            out_data_reg <= {clamp_byte(mat_sum.chroma_red),
                             clamp_byte(mat_sum.chroma_blue),
                             clamp_byte(mat_sum.luma)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### sv/rgbay_check.sv
`default_nettype none

module rgbay_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // pipeline never refuses an item when the output drains
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled with output free");

    // output empty after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // configuration never back-pressures
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rgba_blend_to_ycbcr444 rgbay_check u_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbay_pkg::*;

    // address with no register behind it, writes to it must be dropped
    localparam cfg_index_t RegUnused = 2'd3;

    // bt.601 full range weights, 16 fraction bits
    localparam longint WYR = 19595, WYG = 38470, WYB = 7471;
    localparam longint WBR = 11056, WBG = 21712, WBB = 32768;
    localparam longint WRR = 32768, WRG = 27440, WRB = 5328;
    localparam longint ChromaMid = 128 * 65536;

    localparam int RandomPhases   = 6;
    localparam int PixelsPerPhase = 150;
    localparam int SettleCycles   = 8;     // pipeline is five deep
    localparam int ReportLimit    = 10;

    // first field in the lowest bits, as on the bus
    typedef struct packed {
        chan_t alpha;
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    typedef struct packed {
        chan_t chroma_red;
        chan_t chroma_blue;
        chan_t luma;
    } ycc_t;

    // directed table: background, pixel, and the result where it is plain
    typedef struct packed {
        chan_t bg_red;
        chan_t bg_green;
        chan_t bg_blue;
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        bit    known;
        chan_t luma;
        chan_t chroma_blue;
        chan_t chroma_red;
    } row_t;

    localparam int DirectedRows = 20;
    localparam row_t Directed [DirectedRows] = '{
        // black background after reset, primaries and white opaque
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd0,   8'd128, 8'd128},
        '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd128, 8'd128},
        '{8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 1'b1, 8'd76,  8'd84,  8'd255},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd255, 1'b1, 8'd149, 8'd43,  8'd21},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 8'd29,  8'd255, 8'd107},
        // fully transparent shows the background only
        '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 8'd0,   8'd128, 8'd128},
        '{8'd0,   8'd0,   8'd0,   8'd200, 8'd100, 8'd50,  8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd0,   8'h55,  8'haa,  8'h55,  8'haa,  1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd0,   8'haa,  8'h55,  8'haa,  8'h55,  1'b0, 8'd0,   8'd0,   8'd0},
        // white background
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 8'd128, 8'd128},
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 1'b1, 8'd0,   8'd128, 8'd128},
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255, 8'd17,  8'd34,  8'd51,  8'd127, 1'b0, 8'd0,   8'd0,   8'd0},
        // single-primary backgrounds
        '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd76,  8'd84,  8'd255},
        '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd64,  1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd0,   8'd0,   8'd255, 8'd10,  8'd20,  8'd30,  8'd0,   1'b1, 8'd29,  8'd255, 8'd107},
        '{8'd0,   8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b1, 8'd149, 8'd43,  8'd21},
        // arbitrary background, partial alpha
        '{8'd12,  8'd200, 8'd77,  8'd255, 8'd0,   8'd255, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd12,  8'd200, 8'd77,  8'd0,   8'd255, 8'd0,   8'd100, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;    // red, green, blue, alpha
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // luma, chroma_blue, chroma_red
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = RegBackRed;
    logic [7:0]  cfg_data = '0;

    // predictor copy of the background registers
    chan_t bg_red = '0;
    chan_t bg_green = '0;
    chan_t bg_blue = '0;

    ycc_t expected_ycc [$];
    int   mismatch_count = 0;
    int   pixels_checked = 0;
    int   settings_count = 0;
    bit   calm = 1'b0;            // phase with no idling on either side
    int   stall_left = 0;

    rgba_blend_to_ycbcr444 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // weights the channel extremes a little
    function automatic chan_t pick_channel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 8'd0;
        end else if (r == 1) begin
            return 8'd255;
        end
        return chan_t'($urandom_range(0, 255));
    endfunction

    function automatic pixel_t pick_pixel();
        pixel_t p;
        int     r;
        p.red   = pick_channel();
        p.green = pick_channel();
        p.blue  = pick_channel();
        r = $urandom_range(0, 9);
        if (r < 2) begin
            p.alpha = 8'd0;
        end else if (r < 4) begin
            p.alpha = 8'd255;
        end else begin
            p.alpha = chan_t'($urandom_range(0, 255));
        end
        return p;
    endfunction

    // composite over the background, rounded down
    function automatic longint blend(chan_t fg, chan_t bg, chan_t a);
        return (longint'(fg) * a + longint'(bg) * (255 - a)) / 255;
    endfunction

    // drop the fraction, then clamp to a byte
    function automatic chan_t to_byte(longint sum);
        longint v;
        if (sum < 0) begin
            return 8'd0;
        end
        v = sum >>> 16;
        return (v > 255) ? 8'd255 : chan_t'(v);
    endfunction

    function automatic ycc_t convert_pixel(pixel_t p);
        longint r, g, b;
        ycc_t   y;
        r = blend(p.red, bg_red, p.alpha);
        g = blend(p.green, bg_green, p.alpha);
        b = blend(p.blue, bg_blue, p.alpha);
        y.luma        = to_byte(WYR * r + WYG * g + WYB * b);
        y.chroma_blue = to_byte(-WBR * r - WBG * g + WBB * b + ChromaMid);
        y.chroma_red  = to_byte(WRR * r - WRG * g - WRB * b + ChromaMid);
        return y;
    endfunction

    function automatic void apply_reg_write(cfg_index_t idx, chan_t data);
        case (idx)
            RegBackRed:   bg_red = data;
            RegBackGreen: bg_green = data;
            RegBackBlue:  bg_blue = data;
            default: ;    // no such register
        endcase
    endfunction

    // entered at a falling edge, left at a falling edge with cfg_valid still high
    task automatic write_reg(cfg_index_t idx, chan_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg_write(idx, data);
        @(negedge aclk);
    endtask

    // registers change only with the pipeline empty
    task automatic set_background(chan_t r, chan_t g, chan_t b);
        s_tvalid <= 1'b0;
        while (expected_ycc.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
        @(negedge aclk);
        write_reg(RegBackRed, r);
        write_reg(RegBackGreen, g);
        write_reg(RegBackBlue, b);
        // stray write to the unused address must not disturb anything
        write_reg(RegUnused, chan_t'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // entered and left at a falling edge; the expectation is queued on acceptance
    task automatic push_pixel(pixel_t pix, bit known, ycc_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        expected_ycc.push_back(known ? want : convert_pixel(pix));
        @(negedge aclk);
    endtask

    // output side stalls, same mix of short and long as the input side
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // compare every result against the oldest expectation
    always @(posedge aclk) begin
        ycc_t got;
        ycc_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_ycc.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit) begin
                    $display("unexpected item: luma %0d cb %0d cr %0d",
                             got.luma, got.chroma_blue, got.chroma_red);
                end
            end else begin
                want = expected_ycc.pop_front();
                pixels_checked++;
                if (got.luma !== want.luma || got.chroma_blue !== want.chroma_blue ||
                        got.chroma_red !== want.chroma_red) begin
                    mismatch_count++;
                    if (mismatch_count <= ReportLimit) begin
                        $display("mismatch at %0t: expected y %0d cb %0d cr %0d, got y %0d cb %0d cr %0d",
                                 $realtime, want.luma, want.chroma_blue, want.chroma_red,
                                 got.luma, got.chroma_blue, got.chroma_red);
                    end
                end
            end
        end
    end

    initial begin
        row_t   row;
        pixel_t pix;
        ycc_t   want;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, first rows run on the reset background
        for (int i = 0; i < DirectedRows; i++) begin
            row = Directed[i];
            if (row.bg_red != bg_red || row.bg_green != bg_green || row.bg_blue != bg_blue) begin
                set_background(row.bg_red, row.bg_green, row.bg_blue);
            end
            pix  = '{alpha: row.alpha, blue: row.blue, green: row.green, red: row.red};
            want = '{chroma_red: row.chroma_red, chroma_blue: row.chroma_blue, luma: row.luma};
            push_pixel(pix, row.known, want);
        end

        // random part, one background per phase, black and white among them
        for (int p = 0; p < RandomPhases; p++) begin
            calm = (p == 2);
            if (p == 0) begin
                set_background(8'd0, 8'd0, 8'd0);
            end else if (p == 1) begin
                set_background(8'd255, 8'd255, 8'd255);
            end else begin
                set_background(pick_channel(), pick_channel(), pick_channel());
            end
            repeat (PixelsPerPhase) push_pixel(pick_pixel(), 1'b0, '0);
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        while (expected_ycc.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);

        $display("summary: %0d pixels checked over %0d background settings, %0d mismatches",
                 pixels_checked, settings_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
